/* rtl/rsp_pkg.sv */
// Shared types, constants and GF(256) multiply for the Reed-Solomon parity encoder.
// No dependencies; imported by every module of the block.
package rsp_pkg;

  localparam int PARITY_MAX = 32;
  localparam int BYTE_W     = 8;
  localparam int POLY_W     = 9;
  localparam int COUNT_W    = 6;                     // parity_count register field
  localparam int INDEX_W    = 6;                     // coeff_index input field
  localparam int SLOT_W     = $clog2(PARITY_MAX);    // index into a register row
  localparam int FILL_W     = $clog2(PARITY_MAX + 1); // holds 0..PARITY_MAX
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;

  localparam logic [POLY_W-1:0]  POLY_RESET  = 9'h11D;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 6'd16;

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_MSG  = 1'b1
  } func_t;

  typedef enum logic {
    REG_FIELD_POLY   = 1'b0,
    REG_PARITY_COUNT = 1'b1
  } reg_idx_t;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef byte_t [PARITY_MAX-1:0] byte_vec_t;

  typedef struct packed {
    byte_t             poly_low;
    logic [FILL_W-1:0] n;
  } cfg_t;

  typedef struct packed {
    logic              load;
    logic [FILL_W-1:0] n;
  } snap_t;

  // Shift-and-add field multiply; bit 8 leaving the multiplicand folds in poly_low.
  function automatic byte_t gf_mul(byte_t a, byte_t b, byte_t low);
    byte_t      acc;
    logic [8:0] y;
    acc = '0;
    y   = {1'b0, b};
    for (int i = 0; i < BYTE_W; i++) begin
      if (a[i]) acc = acc ^ y[7:0];
      y = {y[7:0], 1'b0};
      if (y[8]) y = {1'b0, y[7:0] ^ low};
    end
    return acc;
  endfunction

endpackage

/* rtl/rsp_cfg.sv */
// APB-style register file: field polynomial and parity count.
// Depends on rsp_pkg; hands the saturated count and low polynomial bits onward.
module rsp_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rsp_pkg::ADDR_W-1:0] paddr,
  input  logic [rsp_pkg::DATA_W-1:0] pwdata,
  output logic [rsp_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output rsp_pkg::cfg_t              cfg
);
  import rsp_pkg::*;

  logic [POLY_W-1:0]  poly_r, poly_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               wr;
  reg_idx_t           sel;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign sel    = reg_idx_t'(paddr[2]);

  always_comb begin
    poly_nxt  = poly_r;
    count_nxt = count_r;
    if (wr) begin
      unique case (sel)
        REG_FIELD_POLY:   poly_nxt  = pwdata[POLY_W-1:0];
        REG_PARITY_COUNT: count_nxt = pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r  <= POLY_RESET;
      count_r <= COUNT_RESET;
    end else begin
      poly_r  <= poly_nxt;
      count_r <= count_nxt;
    end
  end

  always_comb begin
    unique case (sel)
      REG_FIELD_POLY:   prdata = DATA_W'(poly_r);
      REG_PARITY_COUNT: prdata = DATA_W'(count_r);
      default:          prdata = '0;
    endcase
  end

  // effective parity count, zero acts as one and anything above PARITY_MAX as PARITY_MAX
  always_comb begin
    cfg.poly_low = poly_r[BYTE_W-1:0];
    if (count_r == '0)
      cfg.n = FILL_W'(1);
    else if (int'(count_r) > PARITY_MAX)
      cfg.n = FILL_W'(PARITY_MAX);
    else
      cfg.n = FILL_W'(count_r);
  end

  a_n_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg.n != '0) && (int'(cfg.n) <= PARITY_MAX))
    else $error("effective parity count out of range");
  a_poly_write: assert property (@(posedge clk) disable iff (!rst_n)
    (wr && sel == REG_FIELD_POLY) |=> (poly_r == $past(pwdata[POLY_W-1:0])))
    else $error("field polynomial write lost");
  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr && sel == REG_PARITY_COUNT) |=> $stable(count_r))
    else $error("parity count changed without a write");

endmodule

/* rtl/rsp_lfsr.sv */
// Generator coefficient store and GF(256) division register, one GF multiplier per tap.
// Depends on rsp_pkg; passes the remainder snapshot to rsp_drain on a final message byte.
module rsp_lfsr (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  rsp_pkg::func_t              func,
  input  logic [rsp_pkg::INDEX_W-1:0] coeff_index,
  input  rsp_pkg::byte_t              value,
  input  logic                        msg_last,
  input  rsp_pkg::cfg_t               cfg,
  output rsp_pkg::byte_vec_t          snap_data,
  output rsp_pkg::snap_t              snap
);
  import rsp_pkg::*;

  byte_vec_t rem_r, rem_nxt;
  byte_vec_t gen_r, gen_nxt;
  byte_vec_t shifted, upd;
  byte_t     fb;
  logic      msg_go, load_go;
  logic [INDEX_W-1:0] slot_full;

  assign msg_go    = accept && (func == FUNC_MSG);
  assign load_go   = accept && (func == FUNC_LOAD);
  assign fb        = value ^ rem_r[0];
  assign shifted   = rem_r >> BYTE_W;     // top tap takes zero
  assign slot_full = coeff_index - INDEX_W'(1);

  always_comb begin
    for (int k = 0; k < PARITY_MAX; k++) begin
      if (k < int'(cfg.n)) begin
        if (k + 1 < int'(cfg.n))
          upd[k] = shifted[k] ^ gf_mul(fb, gen_r[k], cfg.poly_low);
        else
          upd[k] = gf_mul(fb, gen_r[k], cfg.poly_low);
      end else begin
        upd[k] = rem_r[k];
      end
    end
  end

  always_comb begin
    rem_nxt = rem_r;
    gen_nxt = gen_r;
    if (msg_go) rem_nxt = msg_last ? '0 : upd;
    if (load_go && coeff_index != '0 && int'(coeff_index) <= PARITY_MAX)
      gen_nxt[slot_full[SLOT_W-1:0]] = value;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
      gen_r <= '0;
    end else begin
      rem_r <= rem_nxt;
      gen_r <= gen_nxt;
    end
  end

  assign snap_data = upd;
  assign snap.load = msg_go && msg_last;
  assign snap.n    = cfg.n;

  a_clear_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    snap.load |=> (rem_r == '0))
    else $error("remainder not cleared after parity run");
  a_load_keeps_rem: assert property (@(posedge clk) disable iff (!rst_n)
    load_go |=> $stable(rem_r))
    else $error("coefficient load disturbed the remainder");
  a_msg_keeps_gen: assert property (@(posedge clk) disable iff (!rst_n)
    !load_go |=> $stable(gen_r))
    else $error("generator coefficients changed without a load");

endmodule

/* rtl/rsp_drain.sv */
// Parity output buffer: holds one remainder snapshot and shifts it out a byte per request.
// Depends on rsp_pkg; fed by rsp_lfsr.
module rsp_drain (
  input  logic               clk,
  input  logic               rst_n,
  input  rsp_pkg::snap_t     snap,
  input  rsp_pkg::byte_vec_t snap_data,
  input  logic               out_stall,
  output logic               out_valid,
  output rsp_pkg::byte_t     out_parity_byte,
  output logic               out_parity_last,
  output logic               busy
);
  import rsp_pkg::*;

  byte_vec_t         buf_r, buf_nxt;
  logic [FILL_W-1:0] cnt_r, cnt_nxt;
  logic              pop;

  assign out_valid       = (cnt_r != '0);
  assign busy            = out_valid;
  assign pop             = out_valid && !out_stall;
  assign out_parity_byte = buf_r[0];
  assign out_parity_last = (cnt_r == FILL_W'(1));

  always_comb begin
    buf_nxt = buf_r;
    cnt_nxt = cnt_r;
    if (snap.load) begin
      buf_nxt = snap_data;
      cnt_nxt = snap.n;
    end else if (pop) begin
      buf_nxt = buf_r >> BYTE_W;
      cnt_nxt = cnt_r - FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    buf_r <= buf_nxt;
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    snap.load |-> (cnt_r == '0))
    else $error("snapshot loaded over an undelivered parity run");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(cnt_r) <= PARITY_MAX)
    else $error("parity count register out of range");
  a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
    snap.load |=> (cnt_r == $past(snap.n)))
    else $error("parity run length not taken from snapshot");

endmodule

/* rtl/reed_solomon_parity_encoder_top.sv */
// Reed-Solomon systematic parity encoder over GF(256), top level.
// Depends on rsp_pkg, rsp_cfg, rsp_lfsr and rsp_drain.
//
// Usage: load generator coefficients g1..gn with func=0 (coeff_index 1 is the term just
// below the implicit leading 1), then send message bytes with func=1, one request per
// clock. All n remainder taps update in the same cycle through one GF multiplier per
// tap, so loads and message bytes are taken at one per cycle while in_stall is low. On
// the request flagged msg_last the remainder is copied into an output buffer and the
// division register is cleared; the buffer then delivers n parity bytes, highest order
// first, one per cycle that out_stall is low, the last one flagged with out_parity_last.
// The next codeword's bytes keep flowing while that happens; only its final byte waits
// (in_stall high) until the previous parity run has fully left the buffer, which frees
// up in the cycle after the last parity byte goes out. Field polynomial and parity
// count come from the APB registers at byte addresses 0 and 4; change them only while
// no codeword is in progress. Reset values: polynomial 0x11D, count 16; a count of 0
// acts as 1 and anything above 32 as 32.
module reed_solomon_parity_encoder_top (
  input  logic                        clk,
  input  logic                        rst_n,
  // request channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_func,
  input  logic [rsp_pkg::INDEX_W-1:0] in_coeff_index,
  input  logic [rsp_pkg::BYTE_W-1:0]  in_value,
  input  logic                        in_msg_last,
  // parity channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [rsp_pkg::BYTE_W-1:0]  out_parity_byte,
  output logic                        out_parity_last,
  // register port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rsp_pkg::ADDR_W-1:0]  paddr,
  input  logic [rsp_pkg::DATA_W-1:0]  pwdata,
  output logic [rsp_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import rsp_pkg::*;

  cfg_t      cfg;
  snap_t     snap;
  byte_vec_t snap_data;
  logic      busy;
  logic      accept;
  func_t     func;

  assign func = func_t'(in_func);

  // only a final message byte needs the output buffer; hold it back while busy
  assign in_stall = busy && (func == FUNC_MSG) && in_msg_last;
  assign accept   = in_valid && !in_stall;

  rsp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rsp_lfsr u_lfsr (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .func        (func),
    .coeff_index (in_coeff_index),
    .value       (in_value),
    .msg_last    (in_msg_last),
    .cfg         (cfg),
    .snap_data   (snap_data),
    .snap        (snap)
  );

  rsp_drain u_drain (
    .clk             (clk),
    .rst_n           (rst_n),
    .snap            (snap),
    .snap_data       (snap_data),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_parity_byte (out_parity_byte),
    .out_parity_last (out_parity_last),
    .busy            (busy)
  );

endmodule
